// ----- sv/fgl_pkg.sv -----
package fgl_pkg;

  localparam int LANES = 4;
  localparam int NSTG = 19;

  localparam logic [31:0] ONE_Q = 32'd33554432;
  localparam logic [31:0] SIX_Q = 32'd201326592;
  localparam logic [31:0] C_U = 32'd26772563;
  localparam logic [31:0] C_K = 32'd1500386;
  localparam logic [31:0] C_A1 = 32'd4301850;
  localparam logic [31:0] C_A2 = 32'd93859;
  localparam logic [31:0] C_A3 = 32'd248;
  localparam logic [31:0] C_B1 = 32'd15486661;
  localparam logic [31:0] C_B2 = 32'd782155;
  localparam logic [31:0] C_B3 = 32'd6952;
  localparam logic [31:0] SEED_MAGIC = 32'h7EF311C2;

  typedef struct packed {
    logic        msk;
    logic        sgn;
    logic        spec;
    logic [15:0] spec_val;
    logic [27:0] mag;
  } fgl_side_t;

  function automatic logic [38:0] mulq(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] pr;
    pr = {32'd0, a} * {32'd0, b} + 64'd16777216;
    return pr[63:25];
  endfunction

  function automatic logic [4:0] msb32(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

// ----- sv/fgl_ctl.sv -----
module fgl_ctl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fgl_pkg::NSTG-1:0]    en
);

  logic [fgl_pkg::NSTG-1:0] vld_r;
  logic [fgl_pkg::NSTG:0]   rdy;

  always_comb begin
    rdy[fgl_pkg::NSTG] = out_ready;
    for (int k = fgl_pkg::NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign en = rdy[fgl_pkg::NSTG-1:0];
  assign in_ready = rdy[0];
  assign out_valid = vld_r[fgl_pkg::NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < fgl_pkg::NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

endmodule

// ----- sv/fgl_lane.sv -----
module fgl_lane (
  input  logic                        clk,
  input  logic [fgl_pkg::NSTG-1:0]    en,
  input  logic [15:0]                 half_in,
  input  logic                        msk_in,
  output logic [15:0]                 half_out,
  output logic                        msk_out
);

  function automatic logic [31:0] seed(input logic [31:0] d, input logic [4:0] p);
    logic [31:0] mant;
    logic [31:0] bits;
    logic [31:0] yb;
    logic [31:0] sig;
    logic [7:0]  ey;
    logic [7:0]  sh;
    logic [7:0]  be;
    mant = d >> (p - 5'd23);
    be = 8'd102 + {3'd0, p};
    bits = {1'b0, be, mant[22:0]};
    yb = fgl_pkg::SEED_MAGIC - bits;
    ey = yb[30:23];
    sig = {8'd0, 1'b1, yb[22:0]};
    if (ey >= 8'd125) begin
      sh = ey - 8'd125;
      if (sh > 8'd8) begin
        sh = 8'd8;
      end
      return sig << sh[3:0];
    end else begin
      sh = 8'd125 - ey;
      if (sh >= 8'd32) begin
        return 32'd0;
      end
      return sig >> sh[4:0];
    end
  endfunction

  fgl_pkg::fgl_side_t sd_r [fgl_pkg::NSTG];
  fgl_pkg::fgl_side_t sd0;

  logic [30:0] x2_r;
  logic [26:0] kx2_r;
  logic [29:0] s_r;
  logic [27:0] u4_r, u5_r, u6_r, u7_r, u8_r;
  logic [30:0] v2_5_r, v2_6_r, v2_7_r;
  logic [31:0] p6_r, p7_r, p8_r, q6_r, q7_r, q8_r;
  logic [31:0] q9_r, q10_r, q11_r, q12_r, q13_r;
  logic [31:0] num9_r, num10_r, num11_r, num12_r, num13_r, num14_r;
  logic [4:0]  qm9_r;
  logic [31:0] y0_r, y0b_r, y1_r, y1b_r, y2_r;
  logic [26:0] t11_r, t13_r;
  logic [26:0] onep_r;
  logic [27:0] g16_r, g17_r;
  logic [4:0]  gm_r;
  logic [15:0] res_r;

  logic [38:0] m3, m4, m11, m13, m15;
  logic [31:0] th;
  logic [55:0] gp;
  logic [4:0]  hs;
  logic [27:0] hm, hrem, hhalf, hres;

  always_comb begin
    logic [4:0] e;
    e = half_in[14:10];
    sd0.msk = msk_in;
    sd0.sgn = half_in[15];
    sd0.spec = (e == 5'd31) || (e >= 5'd18);
    sd0.spec_val = (e == 5'd31 && half_in[9:0] != 10'd0) ? half_in :
                   (half_in[15] ? 16'h8000 : half_in);
    sd0.mag = {17'd0, (e != 5'd0), half_in[9:0]} << ((e != 5'd0) ? e : 5'd1);
  end

  always_comb begin
    m3 = fgl_pkg::mulq({5'd0, kx2_r}, {4'd0, sd_r[2].mag});
    m4 = fgl_pkg::mulq(fgl_pkg::C_U, {2'd0, s_r});
    m11 = fgl_pkg::mulq(q10_r, y0_r);
    m13 = fgl_pkg::mulq(q12_r, y1_r);
    m15 = fgl_pkg::mulq(num14_r, y2_r);
    th = (m15 > {7'd0, fgl_pkg::ONE_Q}) ? fgl_pkg::ONE_Q : m15[31:0];
    gp = {28'd0, sd_r[15].mag} * {29'd0, onep_r} + 56'd33554432;
    hs = (gm_r >= 5'd11) ? gm_r - 5'd10 : 5'd1;
    hm = g17_r >> hs;
    hrem = g17_r & ((28'd1 << hs) - 28'd1);
    hhalf = 28'd1 << (hs - 5'd1);
    if (hrem > hhalf || (hrem == hhalf && hm[0])) begin
      hm = hm + 28'd1;
    end
    hres = (gm_r >= 5'd11) ? ({23'd0, gm_r - 5'd10} << 10) + hm - 28'd1024 : hm;
  end

  always_ff @(posedge clk) begin
    if (en[0]) sd_r[0] <= sd0;
    for (int k = 1; k < fgl_pkg::NSTG; k++) begin
      if (en[k]) sd_r[k] <= sd_r[k-1];
    end
    if (en[1]) x2_r <= 31'(fgl_pkg::mulq({4'd0, sd_r[0].mag}, {4'd0, sd_r[0].mag}));
    if (en[2]) kx2_r <= 27'(fgl_pkg::mulq(fgl_pkg::C_K, {1'd0, x2_r}));
    if (en[3]) s_r <= {2'd0, sd_r[2].mag} + m3[29:0];
    if (en[4]) u4_r <= (m4 > {7'd0, fgl_pkg::SIX_Q}) ? fgl_pkg::SIX_Q[27:0] : m4[27:0];
    if (en[5]) begin
      u5_r <= u4_r;
      v2_5_r <= 31'(fgl_pkg::mulq({4'd0, u4_r}, {4'd0, u4_r}));
    end
    if (en[6]) begin
      u6_r <= u5_r;
      v2_6_r <= v2_5_r;
      p6_r <= 32'(fgl_pkg::mulq(fgl_pkg::C_A3, {1'd0, v2_5_r})) + fgl_pkg::C_A2;
      q6_r <= 32'(fgl_pkg::mulq(fgl_pkg::C_B3, {1'd0, v2_5_r})) + fgl_pkg::C_B2;
    end
    if (en[7]) begin
      u7_r <= u6_r;
      v2_7_r <= v2_6_r;
      p7_r <= 32'(fgl_pkg::mulq(p6_r, {1'd0, v2_6_r})) + fgl_pkg::C_A1;
      q7_r <= 32'(fgl_pkg::mulq(q6_r, {1'd0, v2_6_r})) + fgl_pkg::C_B1;
    end
    if (en[8]) begin
      u8_r <= u7_r;
      p8_r <= 32'(fgl_pkg::mulq(p7_r, {1'd0, v2_7_r})) + fgl_pkg::ONE_Q;
      q8_r <= 32'(fgl_pkg::mulq(q7_r, {1'd0, v2_7_r})) + fgl_pkg::ONE_Q;
    end
    if (en[9]) begin
      num9_r <= 32'(fgl_pkg::mulq({4'd0, u8_r}, p8_r));
      q9_r <= q8_r;
      qm9_r <= fgl_pkg::msb32(q8_r);
    end
    if (en[10]) begin
      num10_r <= num9_r;
      q10_r <= q9_r;
      y0_r <= seed(q9_r, qm9_r);
    end
    if (en[11]) begin
      num11_r <= num10_r;
      q11_r <= q10_r;
      y0b_r <= y0_r;
      t11_r <= (m11 >= 39'd67108864) ? 27'd0 : 27'd67108864 - m11[26:0];
    end
    if (en[12]) begin
      num12_r <= num11_r;
      q12_r <= q11_r;
      y1_r <= 32'(fgl_pkg::mulq(y0b_r, {5'd0, t11_r}));
    end
    if (en[13]) begin
      num13_r <= num12_r;
      q13_r <= q12_r;
      y1b_r <= y1_r;
      t13_r <= (m13 >= 39'd67108864) ? 27'd0 : 27'd67108864 - m13[26:0];
    end
    if (en[14]) begin
      num14_r <= num13_r;
      y2_r <= 32'(fgl_pkg::mulq(y1b_r, {5'd0, t13_r}));
    end
    if (en[15]) begin
      onep_r <= sd_r[14].sgn ? 27'(fgl_pkg::ONE_Q - th) : 27'(fgl_pkg::ONE_Q + th);
    end
    if (en[16]) g16_r <= gp[53:26];
    if (en[17]) begin
      g17_r <= g16_r;
      gm_r <= fgl_pkg::msb32({4'd0, g16_r});
    end
    if (en[18]) begin
      if (!sd_r[17].msk) begin
        res_r <= 16'd0;
      end else if (sd_r[17].spec) begin
        res_r <= sd_r[17].spec_val;
      end else begin
        res_r <= {sd_r[17].sgn, hres[14:0]};
      end
    end
  end

  assign half_out = res_r;
  assign msk_out = sd_r[fgl_pkg::NSTG-1].msk;

endmodule

// ----- sv/fp16_gelu_tanh_lanes_core.sv -----
// GELU (tanh form) on four binary16 values per transaction.
// Input channel: in_valid/in_ready with in_half_in0..3 and in_lane_mask_in.
// Output channel: out_valid/out_ready with out_half_out0..3 and
// out_lane_mask_out, which copies the input mask; masked-off lanes read zero.
// Each lane is a 19-stage pipeline in fixed point with at most two multipliers
// per stage, and out_valid is the valid bit of its last stage. One transaction is
// accepted per cycle while in_ready is high.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so an empty stage anywhere lets a new transaction in
// while a finished result still waits on the output.
// When the receiver holds out_ready low the pipeline fills up and in_ready
// falls once every stage is full; nothing is dropped.
// Synchronous reset clears all valid bits; the data registers are not reset.
module fp16_gelu_tanh_lanes_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_half_in0,
  input  logic [15:0] in_half_in1,
  input  logic [15:0] in_half_in2,
  input  logic [15:0] in_half_in3,
  input  logic [3:0]  in_lane_mask_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_half_out0,
  output logic [15:0] out_half_out1,
  output logic [15:0] out_half_out2,
  output logic [15:0] out_half_out3,
  output logic [3:0]  out_lane_mask_out
);

  logic [fgl_pkg::NSTG-1:0]  en;
  logic [15:0]               hin  [fgl_pkg::LANES];
  logic [15:0]               hout [fgl_pkg::LANES];
  logic [fgl_pkg::LANES-1:0] mout;

  assign hin[0] = in_half_in0;
  assign hin[1] = in_half_in1;
  assign hin[2] = in_half_in2;
  assign hin[3] = in_half_in3;

  fgl_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  for (genvar i = 0; i < fgl_pkg::LANES; i++) begin : g_lane
    fgl_lane u_lane (
      .clk      (clk),
      .en       (en),
      .half_in  (hin[i]),
      .msk_in   (in_lane_mask_in[i]),
      .half_out (hout[i]),
      .msk_out  (mout[i])
    );
  end

  assign out_half_out0 = hout[0];
  assign out_half_out1 = hout[1];
  assign out_half_out2 = hout[2];
  assign out_half_out3 = hout[3];
  assign out_lane_mask_out = mout;

endmodule
